FILE: sv/ppsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppsd_pkg;

    // Result format: 18-bit signed distance
    localparam int OUT_W = 18;

    localparam logic signed [OUT_W-1:0] DIST_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] DIST_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] DIST_ZERO = '0;

endpackage

`default_nettype wire

FILE: sv/ppsd_geom.sv
`timescale 1ns / 1ps
`default_nettype none

// Edge vectors, cross-product terms and the plane normal: three stages.
module ppsd_geom #(
    parameter int CW = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   valid_in,
    input  logic signed [CW-1:0]   pt [3],
    input  logic signed [CW-1:0]   va [3],
    input  logic signed [CW-1:0]   vb [3],
    input  logic signed [CW-1:0]   vc [3],
    output logic                   valid_out,
    output logic signed [2*CW+2:0] nrm [3],
    output logic signed [CW:0]     wv [3]
);

    localparam int UW = CW + 1;
    localparam int XW = 2 * UW;
    localparam int NW = XW + 1;

    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [UW-1:0] u_reg [3], u_next [3];
    logic signed [UW-1:0] v_reg [3], v_next [3];
    logic signed [UW-1:0] w1_reg [3], w1_next [3];
    logic signed [UW-1:0] w2_reg [3];
    logic signed [UW-1:0] w3_reg [3];
    logic signed [XW-1:0] m_reg [6], m_next [6];
    logic signed [NW-1:0] n_reg [3], n_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_next[i]  = UW'(vb[i]) - UW'(va[i]);
            v_next[i]  = UW'(vc[i]) - UW'(va[i]);
            w1_next[i] = UW'(pt[i]) - UW'(va[i]);
        end
        m_next[0] = u_reg[1] * v_reg[2];
        m_next[1] = u_reg[2] * v_reg[1];
        m_next[2] = u_reg[2] * v_reg[0];
        m_next[3] = u_reg[0] * v_reg[2];
        m_next[4] = u_reg[0] * v_reg[1];
        m_next[5] = u_reg[1] * v_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            n_next[i] = NW'(m_reg[2*i]) - NW'(m_reg[2*i+1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg  <= u_next;
        v_reg  <= v_next;
        w1_reg <= w1_next;
        m_reg  <= m_next;
        w2_reg <= w1_reg;
        n_reg  <= n_next;
        w3_reg <= w2_reg;
    end

    assign valid_out = v3_reg;
    assign nrm       = n_reg;
    assign wv        = w3_reg;

endmodule

`default_nettype wire

FILE: sv/ppsd_prod.sv
`timescale 1ns / 1ps
`default_nettype none

// Normal squared norm and dot product with (p - a), from split half-width products.
module ppsd_prod #(
    parameter int CW = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   valid_in,
    input  logic signed [2*CW+2:0] nrm [3],
    input  logic signed [CW:0]     wv [3],
    output logic                   valid_out,
    output logic [4*CW+7:0]        nn,
    output logic signed [3*CW+5:0] dot
);

    localparam int UW  = CW + 1;
    localparam int NW  = 2 * CW + 3;
    localparam int H   = NW / 2;
    localparam int HW  = NW - H;
    localparam int SQW = 2 * NW;
    localparam int DPW = NW + UW;
    localparam int NNW = SQW + 2;
    localparam int DW  = DPW + 2;

    logic                      v4_reg, v5_reg, v6_reg;
    logic signed [HW-1:0]      nhi [3];
    logic signed [H:0]         nlo [3];
    logic signed [2*HW-1:0]    hh_reg [3], hh_next [3];
    logic signed [HW+H:0]      hl_reg [3], hl_next [3];
    logic signed [2*H+1:0]     ll_reg [3], ll_next [3];
    logic signed [HW+UW-1:0]   dh_reg [3], dh_next [3];
    logic signed [H+UW:0]      dl_reg [3], dl_next [3];
    logic signed [SQW-1:0]     sq_reg [3], sq_next [3];
    logic signed [DPW-1:0]     dp_reg [3], dp_next [3];
    logic signed [NNW-1:0]     nn_reg, nn_next;
    logic signed [DW-1:0]      d_reg, d_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nhi[i]     = nrm[i][NW-1:H];
            nlo[i]     = {1'b0, nrm[i][H-1:0]};
            hh_next[i] = nhi[i] * nhi[i];
            hl_next[i] = nhi[i] * nlo[i];
            ll_next[i] = nlo[i] * nlo[i];
            dh_next[i] = nhi[i] * wv[i];
            dl_next[i] = nlo[i] * wv[i];
            sq_next[i] = (SQW'(hh_reg[i]) <<< (2 * H)) + (SQW'(hl_reg[i]) <<< (H + 1))
                       + SQW'(ll_reg[i]);
            dp_next[i] = (DPW'(dh_reg[i]) <<< H) + DPW'(dl_reg[i]);
        end
        nn_next = NNW'(sq_reg[0]) + NNW'(sq_reg[1]) + NNW'(sq_reg[2]);
        d_next  = DW'(dp_reg[0]) + DW'(dp_reg[1]) + DW'(dp_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= valid_in;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hh_reg <= hh_next;
        hl_reg <= hl_next;
        ll_reg <= ll_next;
        dh_reg <= dh_next;
        dl_reg <= dl_next;
        sq_reg <= sq_next;
        dp_reg <= dp_next;
        nn_reg <= nn_next;
        d_reg  <= d_next;
    end

    assign valid_out = v6_reg;
    assign nn        = nn_reg;
    assign dot       = d_reg;

endmodule

`default_nettype wire

FILE: sv/ppsd_sq.sv
`timescale 1ns / 1ps
`default_nettype none

// Sign and magnitude of the dot product, then its square in two stages.
module ppsd_sq #(
    parameter int CW = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   valid_in,
    input  logic [4*CW+7:0]        nn_in,
    input  logic signed [3*CW+5:0] dot,
    output logic                   valid_out,
    output logic [4*CW+7:0]        nn_out,
    output logic [6*CW+11:0]       d2,
    output logic                   neg,
    output logic                   degen
);

    localparam int NNW = 4 * CW + 8;
    localparam int DW  = 3 * CW + 6;
    localparam int H2  = DW / 2;
    localparam int HW2 = DW - H2;
    localparam int D2W = 2 * DW;

    logic                   v7_reg, v8_reg, v9_reg;
    logic [DW-1:0]          mag_reg, mag_next;
    logic                   neg7_reg, neg8_reg, neg9_reg;
    logic                   dg7_reg, dg8_reg, dg9_reg;
    logic [NNW-1:0]         nn7_reg, nn8_reg, nn9_reg;
    logic [2*HW2-1:0]       hh_reg, hh_next;
    logic [DW-1:0]          hl_reg, hl_next;
    logic [2*H2-1:0]        ll_reg, ll_next;
    logic [D2W-1:0]         d2_reg, d2_next;

    always_comb
    begin
        mag_next = dot[DW-1] ? DW'(-dot) : DW'(dot);
        hh_next  = (2*HW2)'(mag_reg[DW-1:H2]) * (2*HW2)'(mag_reg[DW-1:H2]);
        hl_next  = DW'(mag_reg[DW-1:H2]) * DW'(mag_reg[H2-1:0]);
        ll_next  = (2*H2)'(mag_reg[H2-1:0]) * (2*H2)'(mag_reg[H2-1:0]);
        d2_next  = (D2W'(hh_reg) << (2 * H2)) + (D2W'(hl_reg) << (H2 + 1)) + D2W'(ll_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else
        begin
            v7_reg <= valid_in;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg7_reg <= dot[DW-1];
        dg7_reg  <= (nn_in == '0);
        nn7_reg  <= nn_in;
        hh_reg   <= hh_next;
        hl_reg   <= hl_next;
        ll_reg   <= ll_next;
        neg8_reg <= neg7_reg;
        dg8_reg  <= dg7_reg;
        nn8_reg  <= nn7_reg;
        d2_reg   <= d2_next;
        neg9_reg <= neg8_reg;
        dg9_reg  <= dg8_reg;
        nn9_reg  <= nn8_reg;
    end

    assign valid_out = v9_reg;
    assign nn_out    = nn9_reg;
    assign d2        = d2_reg;
    assign neg       = neg9_reg;
    assign degen     = dg9_reg;

endmodule

`default_nettype wire

FILE: sv/ppsd_root_stage.sv
`timescale 1ns / 1ps
`default_nettype none

// One bit of the quotient: keeps P = q*q*nn and R = q*nn, tries bit K.
// (q + 2^K)^2 nn = P + R*2^(K+1) + nn*2^(2K)
module ppsd_root_stage #(
    parameter int CW = 16,
    parameter int K  = 0
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       valid_in,
    input  logic [((6*CW+12 > 4*CW+8+2*ppsd_pkg::OUT_W) ?
                   6*CW+12 : 4*CW+8+2*ppsd_pkg::OUT_W):0] p_in,
    input  logic [4*CW+7+ppsd_pkg::OUT_W:0]            r_in,
    input  logic [ppsd_pkg::OUT_W-1:0]                 q_in,
    input  logic [6*CW+11:0]                           d2_in,
    input  logic [4*CW+7:0]                            nn_in,
    input  logic                                       neg_in,
    input  logic                                       degen_in,
    output logic                                       valid_out,
    output logic [((6*CW+12 > 4*CW+8+2*ppsd_pkg::OUT_W) ?
                   6*CW+12 : 4*CW+8+2*ppsd_pkg::OUT_W):0] p_out,
    output logic [4*CW+7+ppsd_pkg::OUT_W:0]            r_out,
    output logic [ppsd_pkg::OUT_W-1:0]                 q_out,
    output logic [6*CW+11:0]                           d2_out,
    output logic [4*CW+7:0]                            nn_out,
    output logic                                       neg_out,
    output logic                                       degen_out
);

    localparam int QW  = ppsd_pkg::OUT_W;
    localparam int NNW = 4 * CW + 8;
    localparam int D2W = 6 * CW + 12;
    localparam int RW  = NNW + QW;
    localparam int TW  = ((D2W > NNW + 2 * QW) ? D2W : NNW + 2 * QW) + 1;

    logic           v_reg;
    logic [TW-1:0]  t;
    logic           fit;
    logic [TW-1:0]  p_reg, p_next;
    logic [RW-1:0]  r_reg, r_next;
    logic [QW-1:0]  q_reg, q_next;
    logic [D2W-1:0] d2_reg;
    logic [NNW-1:0] nn_reg;
    logic           neg_reg, dg_reg;

    always_comb
    begin
        t      = p_in + (TW'(r_in) << (K + 1)) + (TW'(nn_in) << (2 * K));
        fit    = (t <= TW'(d2_in));
        p_next = fit ? t : p_in;
        r_next = fit ? (r_in + (RW'(nn_in) << K)) : r_in;
        q_next = fit ? (q_in | (QW'(1) << K)) : q_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        d2_reg  <= d2_in;
        nn_reg  <= nn_in;
        neg_reg <= neg_in;
        dg_reg  <= degen_in;
    end

    assign valid_out = v_reg;
    assign p_out     = p_reg;
    assign r_out     = r_reg;
    assign q_out     = q_reg;
    assign d2_out    = d2_reg;
    assign nn_out    = nn_reg;
    assign neg_out   = neg_reg;
    assign degen_out = dg_reg;

endmodule

`default_nettype wire

FILE: sv/point_plane_signed_distance_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake          | Payload
// ----------+--------------------+---------------------------------------------
// query in  | start, busy        | point_*, vert_a_*, vert_b_*, vert_c_*
// result out| done (one cycle)   | signed_distance, degenerate
//
// Fully pipelined: one query per cycle, busy is never raised.
// From the start edge to the done cycle a query passes through
// 9 stages of products and sums, then one stage per quotient bit of the
// shift-add square root divide, then the output register.
// Reset clears only the valid bits; results cannot be held off downstream.
module point_plane_signed_distance_core #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_WIDTH-1:0]       point_x,
    input  logic signed [COORD_WIDTH-1:0]       point_y,
    input  logic signed [COORD_WIDTH-1:0]       point_z,
    input  logic signed [COORD_WIDTH-1:0]       vert_a_x,
    input  logic signed [COORD_WIDTH-1:0]       vert_a_y,
    input  logic signed [COORD_WIDTH-1:0]       vert_a_z,
    input  logic signed [COORD_WIDTH-1:0]       vert_b_x,
    input  logic signed [COORD_WIDTH-1:0]       vert_b_y,
    input  logic signed [COORD_WIDTH-1:0]       vert_b_z,
    input  logic signed [COORD_WIDTH-1:0]       vert_c_x,
    input  logic signed [COORD_WIDTH-1:0]       vert_c_y,
    input  logic signed [COORD_WIDTH-1:0]       vert_c_z,
    output logic                                done,
    output logic signed [ppsd_pkg::OUT_W-1:0]   signed_distance,
    output logic                                degenerate
);

    localparam int CW  = COORD_WIDTH;
    localparam int QW  = ppsd_pkg::OUT_W;
    localparam int UW  = CW + 1;
    localparam int NW  = 2 * CW + 3;
    localparam int NNW = 4 * CW + 8;
    localparam int DW  = 3 * CW + 6;
    localparam int D2W = 6 * CW + 12;
    localparam int RW  = NNW + QW;
    localparam int TW  = ((D2W > NNW + 2 * QW) ? D2W : NNW + 2 * QW) + 1;
    localparam int LAT = 10 + QW;

    logic signed [CW-1:0] pt [3], va [3], vb [3], vc [3];
    logic                 g_valid;
    logic signed [NW-1:0] g_nrm [3];
    logic signed [UW-1:0] g_wv [3];
    logic                 m_valid;
    logic [NNW-1:0]       m_nn;
    logic signed [DW-1:0] m_dot;

    logic                 rv [QW+1];
    logic [TW-1:0]        rp [QW+1];
    logic [RW-1:0]        rr [QW+1];
    logic [QW-1:0]        rq [QW+1];
    logic [D2W-1:0]       rd2 [QW+1];
    logic [NNW-1:0]       rnn [QW+1];
    logic                 rneg [QW+1];
    logic                 rdg [QW+1];

    logic                 done_reg;
    logic signed [QW-1:0] dist_reg, dist_next;
    logic                 dg_reg;
    logic [QW-1:0]        qf;

    assign pt = '{point_x, point_y, point_z};
    assign va = '{vert_a_x, vert_a_y, vert_a_z};
    assign vb = '{vert_b_x, vert_b_y, vert_b_z};
    assign vc = '{vert_c_x, vert_c_y, vert_c_z};

    assign busy = 1'b0;

    ppsd_geom #(.CW(CW)) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (start),
        .pt        (pt),
        .va        (va),
        .vb        (vb),
        .vc        (vc),
        .valid_out (g_valid),
        .nrm       (g_nrm),
        .wv        (g_wv)
    );

    ppsd_prod #(.CW(CW)) u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (g_valid),
        .nrm       (g_nrm),
        .wv        (g_wv),
        .valid_out (m_valid),
        .nn        (m_nn),
        .dot       (m_dot)
    );

    ppsd_sq #(.CW(CW)) u_sq (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (m_valid),
        .nn_in     (m_nn),
        .dot       (m_dot),
        .valid_out (rv[0]),
        .nn_out    (rnn[0]),
        .d2        (rd2[0]),
        .neg       (rneg[0]),
        .degen     (rdg[0])
    );

    assign rp[0] = '0;
    assign rr[0] = '0;
    assign rq[0] = '0;

    // Most significant quotient bit first; bit QW-1 set means saturation.
    for (genvar s = 0; s < QW; s++)
    begin : g_root
        ppsd_root_stage #(.CW(CW), .K(QW - 1 - s)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (rv[s]),
            .p_in      (rp[s]),
            .r_in      (rr[s]),
            .q_in      (rq[s]),
            .d2_in     (rd2[s]),
            .nn_in     (rnn[s]),
            .neg_in    (rneg[s]),
            .degen_in  (rdg[s]),
            .valid_out (rv[s+1]),
            .p_out     (rp[s+1]),
            .r_out     (rr[s+1]),
            .q_out     (rq[s+1]),
            .d2_out    (rd2[s+1]),
            .nn_out    (rnn[s+1]),
            .neg_out   (rneg[s+1]),
            .degen_out (rdg[s+1])
        );
    end

    assign qf = rq[QW];

    always_comb
    begin
        if (rdg[QW])
        begin
            dist_next = ppsd_pkg::DIST_ZERO;
        end
        else if (qf[QW-1])
        begin
            dist_next = rneg[QW] ? ppsd_pkg::DIST_MIN : ppsd_pkg::DIST_MAX;
        end
        else
        begin
            dist_next = rneg[QW] ? -$signed(qf) : $signed(qf);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= rv[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        dg_reg   <= rdg[QW];
    end

    assign done            = done_reg;
    assign signed_distance = dist_reg;
    assign degenerate      = dg_reg;

    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("transfer did not complete after fixed latency");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching transfer in");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (signed_distance == ppsd_pkg::DIST_ZERO))
        else $error("degenerate result with nonzero distance");

endmodule

`default_nettype wire
